>>> hw/rtl/ole_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list engine package
// Shared command codes, transaction structs and default sizes.
// ----------------------------------------------------------------------------
package ole_pkg;

    // Field widths of the command and result transactions.
    localparam int CMD_W = 3;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int CNT_W = 7;

    // Default sizes of the list store.
    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    // Command transaction.
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
    } t_cmd_s;

    // Result transaction.
    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] read_value;
        logic [CNT_W-1:0] entry_count;
    } t_res_s;

endpackage

>>> hw/rtl/ordered_list_engine_core.sv
// ----------------------------------------------------------------------------
// Ordered list engine core
// Bounded ordered list in a single-port-write memory, walked one entry per
// cycle by a small sequencer for insert, remove, membership and read.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                  Direction  Handshake
//  command   start, busy, i_cmd       in         taken when start && !busy
//  result    o_valid, o_result        out        one-cycle strobe, no stall
//
// Clear, failed inserts and reads, and unknown codes finish in the accepting
// cycle. Insert shifts entries up from the top down to the position, remove
// searches from the front and then closes the gap, membership searches, and
// read waits for the registered read port.
// The memory has one write and one registered read port, so shifting and
// searching move one entry per cycle. For all other commands,
// busy is high from the cycle after acceptance and falls in the cycle that
// carries the result strobe. Reset is synchronous and needs no clearing
// pass: only entries below the count are ever read.

module ordered_list_engine_core #(
    parameter int CAPACITY    = ole_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = ole_pkg::DEF_VALUE_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  ole_pkg::t_cmd_s i_cmd,
    output logic            busy,
    output logic            o_valid,
    output ole_pkg::t_res_s o_result
);

    // Derived sizes.
    localparam int KW = (VALUE_WIDTH < ole_pkg::VAL_W) ? VALUE_WIDTH : ole_pkg::VAL_W;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > ole_pkg::POS_W) ? CW : ole_pkg::POS_W) + 1;

    // Sequencer states.
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INS_SHIFT = 3'd1;
    localparam logic [2:0] S_INS_PUT   = 3'd2;
    localparam logic [2:0] S_SEARCH    = 3'd3;
    localparam logic [2:0] S_DEL_SHIFT = 3'd4;
    localparam logic [2:0] S_RD_WAIT   = 3'd5;

    logic [2:0]      r_state, n_state;
    logic            r_op_del, n_op_del;
    logic [KW-1:0]   r_key, n_key;
    logic [AW-1:0]   r_tgt, n_tgt;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_pend, n_pend;
    logic [AW-1:0]   r_wr_addr, n_wr_addr;
    logic            r_cmp_valid, n_cmp_valid;
    logic [AW-1:0]   r_cmp_idx, n_cmp_idx;
    logic [CW-1:0]   r_count, n_count;
    logic            r_valid, n_valid;
    ole_pkg::t_res_s r_res, n_res;

    // Memory and its ports.
    logic [KW-1:0]   mem [CAPACITY];
    logic [KW-1:0]   r_rd_data;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [KW-1:0]   mem_wd;
    logic            mem_re;
    logic [AW-1:0]   mem_ra;

    // Helpers.
    logic            accept;
    logic [XW-1:0]   pos_x;
    logic [XW-1:0]   cnt_x;
    logic            hit;
    logic            fin;
    logic            fin_ok;
    logic [KW-1:0]   fin_rd;

    assign accept = start && !busy;
    assign pos_x  = XW'(i_cmd.position);
    assign cnt_x  = XW'(r_count);
    assign hit    = r_cmp_valid && (r_rd_data == r_key);

    // Sequencer next-state logic.
    always_comb begin
        n_state     = r_state;
        n_op_del    = r_op_del;
        n_key       = r_key;
        n_tgt       = r_tgt;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_wr_addr   = r_wr_addr;
        n_cmp_valid = r_cmp_valid;
        n_cmp_idx   = r_cmp_idx;
        n_count     = r_count;
        n_valid     = 1'b0;
        n_res       = r_res;
        mem_we      = 1'b0;
        mem_wa      = r_wr_addr;
        mem_wd      = r_rd_data;
        mem_re      = 1'b0;
        mem_ra      = r_idx[AW-1:0];
        fin         = 1'b0;
        fin_ok      = 1'b0;
        fin_rd      = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_key = i_cmd.value[KW-1:0];
                    case (i_cmd.command)
                        ole_pkg::CMD_INSERT: begin
                            if (cnt_x < XW'(CAPACITY) && pos_x != '0 &&
                                pos_x <= cnt_x + XW'(1)) begin
                                n_idx   = r_count;
                                n_tgt   = AW'(pos_x - XW'(1));
                                n_pend  = 1'b0;
                                n_state = S_INS_SHIFT;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        ole_pkg::CMD_REMOVE, ole_pkg::CMD_FIND: begin
                            n_op_del    = (i_cmd.command == ole_pkg::CMD_REMOVE);
                            n_idx       = '0;
                            n_cmp_valid = 1'b0;
                            n_state     = S_SEARCH;
                        end
                        ole_pkg::CMD_READ: begin
                            if (pos_x != '0 && pos_x <= cnt_x) begin
                                mem_re  = 1'b1;
                                mem_ra  = AW'(pos_x - XW'(1));
                                n_state = S_RD_WAIT;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        ole_pkg::CMD_CLEAR: begin
                            n_count = '0;
                            fin     = 1'b1;
                            fin_ok  = 1'b1;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            // Move entries up one place, from the top down to the target.
            S_INS_SHIFT: begin
                mem_we = r_pend;
                if (XW'(r_idx) > XW'(r_tgt)) begin
                    mem_re    = 1'b1;
                    mem_ra    = AW'(r_idx - CW'(1));
                    n_pend    = 1'b1;
                    n_wr_addr = r_idx[AW-1:0];
                    n_idx     = r_idx - CW'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_INS_PUT;
                end
            end

            // Drop the new value into the opened slot.
            S_INS_PUT: begin
                mem_we  = 1'b1;
                mem_wa  = r_tgt;
                mem_wd  = r_key;
                n_count = r_count + CW'(1);
                fin     = 1'b1;
                fin_ok  = 1'b1;
            end

            // Walk the list, comparing each registered read against the key.
            S_SEARCH: begin
                if (hit) begin
                    if (r_op_del) begin
                        n_idx       = CW'(r_cmp_idx) + CW'(1);
                        n_pend      = 1'b0;
                        n_cmp_valid = 1'b0;
                        n_state     = S_DEL_SHIFT;
                    end else begin
                        n_cmp_valid = 1'b0;
                        fin         = 1'b1;
                        fin_ok      = 1'b1;
                    end
                end else if (!r_cmp_valid && r_idx >= r_count) begin
                    fin = 1'b1;
                end else if (r_idx < r_count) begin
                    mem_re      = 1'b1;
                    mem_ra      = r_idx[AW-1:0];
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_idx[AW-1:0];
                    n_idx       = r_idx + CW'(1);
                end else begin
                    n_cmp_valid = 1'b0;
                end
            end

            // Close the gap by moving later entries down one place.
            S_DEL_SHIFT: begin
                mem_we = r_pend;
                if (r_idx < r_count) begin
                    mem_re    = 1'b1;
                    mem_ra    = r_idx[AW-1:0];
                    n_pend    = 1'b1;
                    n_wr_addr = AW'(r_idx - CW'(1));
                    n_idx     = r_idx + CW'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_count = r_count - CW'(1);
                    fin     = 1'b1;
                    fin_ok  = 1'b1;
                end
            end

            S_RD_WAIT: begin
                fin    = 1'b1;
                fin_ok = 1'b1;
                fin_rd = r_rd_data;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Load the result register and return to idle.
        if (fin) begin
            n_valid           = 1'b1;
            n_res.ok          = fin_ok;
            n_res.read_value  = ole_pkg::VAL_W'(fin_rd);
            n_res.entry_count = ole_pkg::CNT_W'(n_count);
            n_state           = S_IDLE;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_cmp_valid <= 1'b0;
            r_count     <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_cmp_valid <= n_cmp_valid;
            r_count     <= n_count;
            r_valid     <= n_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op_del  <= n_op_del;
        r_key     <= n_key;
        r_tgt     <= n_tgt;
        r_idx     <= n_idx;
        r_wr_addr <= n_wr_addr;
        r_cmp_idx <= n_cmp_idx;
        r_res     <= n_res;
    end

    // List memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

`ifndef SYNTHESIS
    // The count never exceeds the store size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_count) <= XW'(CAPACITY))
        else $error("entry count above capacity");

    // A result is only presented once the sequencer is back in idle.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // The count only moves together with a result.
    a_count_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |-> o_valid)
        else $error("count changed without a result");

    // A pending shift write only exists inside a shift phase.
    a_pend_in_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_INS_SHIFT || r_state == S_DEL_SHIFT))
        else $error("shift write pending outside a shift phase");
`endif

endmodule

>>> test/ordered_list_engine_checker.sv
// ----------------------------------------------------------------------------
// Ordered list engine checker
// Watches the command and result channels of the list engine, keeps its own
// copy of the list, and compares every result with the one it predicts.
// ----------------------------------------------------------------------------
module ordered_list_engine_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_busy,
    input  ole_pkg::t_cmd_s i_cmd,
    input  logic            i_valid,
    input  ole_pkg::t_res_s i_result,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked,
    output int              o_list_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import ole_pkg::*;

    localparam int MAX_PRINTED = 40;

    // Shadow copy of the stored list and the results still owed by the block.
    logic [VAL_W-1:0] list_mem [DEF_CAPACITY];
    int               list_len;
    t_res_s           owed_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_list_count = 0;
        list_len     = 0;
    end

    // Prints one line per mismatch, up to a cap, and counts them all.
    task automatic report_mismatch(input string what);
        o_fail_count++;
        if (o_fail_count <= MAX_PRINTED) begin
            $display("checker: mismatch at %0t ns: %s", $realtime, what);
        end
    endtask

    // Applies one command to the shadow list and works out its result.
    task automatic apply_list_command(input t_cmd_s c, output t_res_s r);
        int  pos;
        int  k;
        int  hit;
        pos          = c.position;
        hit          = -1;
        r.ok         = 1'b0;
        r.read_value = '0;
        case (c.command)
            CMD_INSERT: begin
                if (list_len < DEF_CAPACITY && pos >= 1 && pos <= list_len + 1) begin
                    for (k = list_len; k >= pos; k--) begin
                        list_mem[k] = list_mem[k-1];
                    end
                    list_mem[pos-1] = c.value;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            CMD_REMOVE: begin
                for (k = 0; k < list_len; k++) begin
                    if (hit < 0 && list_mem[k] == c.value) begin
                        hit = k;
                    end
                end
                if (hit >= 0) begin
                    for (k = hit; k + 1 < list_len; k++) begin
                        list_mem[k] = list_mem[k+1];
                    end
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            CMD_FIND: begin
                for (k = 0; k < list_len; k++) begin
                    if (list_mem[k] == c.value) begin
                        r.ok = 1'b1;
                    end
                end
            end
            CMD_READ: begin
                if (pos >= 1 && pos <= list_len) begin
                    r.ok         = 1'b1;
                    r.read_value = list_mem[pos-1];
                end
            end
            CMD_CLEAR: begin
                list_len = 0;
                r.ok     = 1'b1;
            end
            default: begin
                // Unused codes leave the list alone and fail.
            end
        endcase
        r.entry_count = list_len[CNT_W-1:0];
    endtask

    // Predicts on every accepted transaction and checks every result strobe.
    always @(posedge i_clk) begin : monitor
        t_res_s want;
        if (!i_rst_n) begin
            list_len = 0;
            owed_results.delete();
        end else begin
            if (i_start && !i_busy) begin
                apply_list_command(i_cmd, want);
                owed_results.push_back(want);
            end
            if (i_valid) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("result strobe with no transaction outstanding");
                end else begin
                    want = owed_results.pop_front();
                    o_checked++;
                    if (i_result.ok !== want.ok) begin
                        report_mismatch($sformatf("ok is %b, predicted %b",
                                                  i_result.ok, want.ok));
                    end
                    if (i_result.read_value !== want.read_value) begin
                        report_mismatch($sformatf("read_value is %h, predicted %h",
                                                  i_result.read_value, want.read_value));
                    end
                    if (i_result.entry_count !== want.entry_count) begin
                        report_mismatch($sformatf("entry_count is %0d, predicted %0d",
                                                  i_result.entry_count, want.entry_count));
                    end
                end
            end
        end
        o_pending    = owed_results.size();
        o_list_count = list_len;
    end

endmodule

>>> test/ordered_list_engine_core_test.sv
// ----------------------------------------------------------------------------
// Ordered list engine testbench
// Drives directed corner cases and then random insert, remove, membership,
// read, clear and unused-code traffic with random gaps; a checker module
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module ordered_list_engine_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ole_pkg::*;

    // Command codes the block does not define.
    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

    localparam int RANDOM_ITEMS = 900;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 80;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} t_mix_e;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    t_cmd_s cmd;
    logic   busy;
    logic   o_valid;
    t_res_s o_result;

    int     fail_count;
    int     pending;
    int     checked;
    int     list_count;
    int     cycle_count;
    int     issued;
    int     peak_count;
    logic   no_gaps;

    ordered_list_engine_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (cmd),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    ordered_list_engine_checker list_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (cmd),
        .i_valid      (o_valid),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_list_count (list_count)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Cycle counter with a hard limit on the run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (list_count > peak_count) begin
            peak_count <= list_count;
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // Presents one transaction after a random gap and waits until it is taken.
    task automatic send(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                        input logic [VAL_W-1:0] val);
        int     gap;
        t_cmd_s c;
        c.command  = op;
        c.position = pos;
        c.value    = val;
        gap        = no_gaps ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap == 0) begin
            start <= 1'b1;
            cmd   <= c;
        end else begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
            start <= 1'b1;
            cmd   <= c;
        end
        do @(posedge i_clk); while (busy);
        issued++;
    endtask

    // Draws a value, mostly from a small pool so that searches and removes hit.
    function automatic logic [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return VAL_W'($urandom_range(0, 15));
        end else if (roll < 65) begin
            return '1;
        end else if (roll < 68) begin
            return {1'b1, {(VAL_W-1){1'b0}}};
        end
        return $urandom();
    endfunction

    // Draws a position: mostly in range for the current depth, sometimes anything.
    function automatic logic [POS_W-1:0] pick_position(input int top_pos);
        if ($urandom_range(0, 9) == 0) begin
            return POS_W'($urandom_range(0, 127));
        end
        return POS_W'($urandom_range(1, (top_pos < 1) ? 1 : top_pos));
    endfunction

    // One random command weighted by the current traffic mix.
    task automatic send_random(input t_mix_e mix);
        int               roll;
        int               ins_cut;
        int               rem_cut;
        int               find_cut;
        int               read_cut;
        int               clr_cut;
        logic [CMD_W-1:0] op;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                ins_cut = 85; rem_cut = 89; find_cut = 93; read_cut = 98; clr_cut = 99;
            end
            MIX_DRAIN: begin
                ins_cut = 12; rem_cut = 60; find_cut = 75; read_cut = 95; clr_cut = 97;
            end
            default: begin
                ins_cut = 30; rem_cut = 50; find_cut = 65; read_cut = 88; clr_cut = 91;
            end
        endcase
        if (roll < ins_cut) begin
            op = CMD_INSERT;
        end else if (roll < rem_cut) begin
            op = CMD_REMOVE;
        end else if (roll < find_cut) begin
            op = CMD_FIND;
        end else if (roll < read_cut) begin
            op = CMD_READ;
        end else if (roll < clr_cut) begin
            op = CMD_CLEAR;
        end else begin
            op = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
        end
        send(op, pick_position((op == CMD_INSERT) ? list_count + 1 : list_count),
             pick_value());
    endtask

    // Stimulus: reset, directed corner cases, then random traffic in segments.
    initial begin : stimulus
        int     done;
        int     seg_len;
        int     k;
        t_mix_e mix;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cycle_count = 0;
        issued      = 0;
        peak_count  = 0;
        no_gaps     = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list: every lookup fails, clear still succeeds.
        send(CMD_READ,   7'd0,   32'h0);
        send(CMD_READ,   7'd1,   32'h0);
        send(CMD_REMOVE, 7'd0,   32'h0);
        send(CMD_FIND,   7'd0,   32'h0);
        send(CMD_CLEAR,  7'd0,   32'h0);
        // Inserts at position zero or past the end fail.
        send(CMD_INSERT, 7'd0,   32'h1234_5678);
        send(CMD_INSERT, 7'd2,   32'h1234_5678);
        send(CMD_INSERT, 7'd127, 32'hFFFF_FFFF);
        // Build A5A5_5A5A, 0, dup 0, all-ones by front, back and middle inserts.
        send(CMD_INSERT, 7'd1,   32'h0);
        send(CMD_INSERT, 7'd2,   32'hFFFF_FFFF);
        send(CMD_INSERT, 7'd2,   32'h0);
        send(CMD_INSERT, 7'd1,   32'hA5A5_5A5A);
        send(CMD_READ,   7'd1,   32'h0);
        send(CMD_READ,   7'd4,   32'h0);
        send(CMD_READ,   7'd5,   32'h0);
        send(CMD_READ,   7'd127, 32'h0);
        send(CMD_FIND,   7'd0,   32'hFFFF_FFFF);
        send(CMD_FIND,   7'd0,   32'h0000_0001);
        // Remove takes only the first of two equal entries.
        send(CMD_REMOVE, 7'd0,   32'h0);
        send(CMD_READ,   7'd2,   32'h0);
        send(CMD_REMOVE, 7'd0,   32'h7777_7777);
        // Unused codes do nothing and fail.
        for (k = CMD_UNUSED_FIRST; k <= CMD_UNUSED_LAST; k++) begin
            send(CMD_W'(k), 7'd1, 32'hFFFF_FFFF);
        end
        send(CMD_CLEAR,  7'd0,   32'h0);

        // Random segments, each with its own mix and gap behavior.
        done = 0;
        while (done < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       mix = MIX_FILL;
                1:       mix = MIX_DRAIN;
                default: mix = MIX_BALANCED;
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            seg_len = $urandom_range(40, 160);
            for (k = 0; k < seg_len && done < RANDOM_ITEMS; k++) begin
                send_random(mix);
                done++;
            end
        end
        @(negedge i_clk);
        start <= 1'b0;

        // Let outstanding results drain, then wait out the settle time.
        wait (pending == 0);
        repeat (SETTLE) @(posedge i_clk);

        $display("tb: %0d commands issued, %0d results checked, list depth peaked at %0d",
                 issued, checked, peak_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches", fail_count);
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ole_pkg.sv
hw/rtl/ordered_list_engine_core.sv
test/ordered_list_engine_checker.sv
test/ordered_list_engine_core_test.sv
